// ----- src/lruet_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruet_pkg: shared types and constants for the LRU eviction tracker
// Key layout, list sizing, capacity reset value and sequencer states.
// ----------------------------------------------------------------------------
package lruet_pkg;

    // List depth; must be a power of two (the list is a ring in the RAM)
    localparam int LIST_DEPTH = 64;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam int KIND_W  = 2;
    localparam int ID_W    = 31;
    localparam int ENTRY_W = KIND_W + ID_W;
    localparam int CAP_W   = 6;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(50);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_MISS,
        ST_APPEND,
        ST_CHECK,
        ST_EVICT_RD,
        ST_EVICT_GET,
        ST_REPORT
    } lruet_state_t;

endpackage

// ----- src/lruet_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruet_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lruet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/lru_eviction_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_eviction_tracker: bounded recency list of (kind, id) keys
// Searches, reorders and trims an LRU list held in a ring buffer in RAM.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to launch one access; the key is sampled on
// that edge. Exactly one result follows per access: done is high for a single
// cycle with was_present, evict_valid, evict_kind and evict_id valid in that
// cycle only. The result cannot be held off, so capture it when done is high.
// The list is walked one entry at a time through a single RAM read port and
// one key comparator. A miss searches the whole list and then appends the key;
// a hit searches up to the key wherever it sits, then does one shift per newer
// key (a read state, then a write state) and writes the key as newest; an
// eviction, where needed, drops the oldest key. busy drops the cycle after
// done, so the next start can be taken in that cycle. Write cfg_wr_data (the
// capacity, reset 50) with cfg_wr_en only while busy is low. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module lru_eviction_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lruet_pkg::KIND_W-1:0]  entry_kind,
    input  logic [lruet_pkg::ID_W-1:0]    entry_id,
    output logic                          done,
    output logic                          was_present,
    output logic                          evict_valid,
    output logic [lruet_pkg::KIND_W-1:0]  evict_kind,
    output logic [lruet_pkg::ID_W-1:0]    evict_id,
    input  logic                          cfg_wr_en,
    input  logic [lruet_pkg::CAP_W-1:0]   cfg_wr_data
);

    lruet_pkg::lruet_state_t state_reg, state_next;

    logic [lruet_pkg::IDX_W-1:0]   idx_reg;
    logic [lruet_pkg::IDX_W-1:0]   head_reg;
    logic [lruet_pkg::CNT_W-1:0]   count_reg;
    logic [lruet_pkg::CAP_W-1:0]   capacity_reg;
    logic                          hit_reg;
    logic                          evicted_reg;
    logic                          appended_reg;
    logic [lruet_pkg::KIND_W-1:0]  key_kind_reg;
    logic [lruet_pkg::ID_W-1:0]    key_id_reg;
    logic [lruet_pkg::KIND_W-1:0]  victim_kind_reg;
    logic [lruet_pkg::ID_W-1:0]    victim_id_reg;

    logic                          ram_we;
    logic [lruet_pkg::IDX_W-1:0]   ram_waddr;
    logic [lruet_pkg::IDX_W-1:0]   ram_raddr;
    logic [lruet_pkg::ENTRY_W-1:0] ram_rdata;
    logic [lruet_pkg::ENTRY_W-1:0] key_entry;

    logic [lruet_pkg::CNT_W-1:0]   idx_ext;
    logic [lruet_pkg::CNT_W-1:0]   cnt_last;
    logic [lruet_pkg::CNT_W-1:0]   append_pos;
    logic                          key_match;
    logic                          over_cap;

    assign key_entry  = {key_kind_reg, key_id_reg};
    assign idx_ext    = lruet_pkg::CNT_W'(idx_reg);
    assign cnt_last   = count_reg - lruet_pkg::CNT_W'(1);
    assign append_pos = hit_reg ? cnt_last : count_reg;
    assign key_match  = (ram_rdata == key_entry);
    assign over_cap   = (count_reg > lruet_pkg::CNT_W'(capacity_reg));

    lruet_ram #(
        .WIDTH (lruet_pkg::ENTRY_W),
        .DEPTH (lruet_pkg::LIST_DEPTH)
    ) u_list_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_we && state_reg == lruet_pkg::ST_APPEND ? key_entry : ram_rdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lruet_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (count_reg == '0) ? lruet_pkg::ST_MISS
                                                   : lruet_pkg::ST_SRCH_RD;
                end
            end
            lruet_pkg::ST_SRCH_RD:
            begin
                state_next = lruet_pkg::ST_SRCH_CMP;
            end
            lruet_pkg::ST_SRCH_CMP:
            begin
                if (key_match)
                begin
                    state_next = (idx_ext == cnt_last) ? lruet_pkg::ST_APPEND
                                                       : lruet_pkg::ST_SHIFT_RD;
                end
                else if (idx_ext + lruet_pkg::CNT_W'(1) == count_reg)
                begin
                    state_next = lruet_pkg::ST_MISS;
                end
                else
                begin
                    state_next = lruet_pkg::ST_SRCH_RD;
                end
            end
            lruet_pkg::ST_SHIFT_RD:
            begin
                state_next = lruet_pkg::ST_SHIFT_WR;
            end
            lruet_pkg::ST_SHIFT_WR:
            begin
                state_next = (idx_ext + lruet_pkg::CNT_W'(2) == count_reg)
                             ? lruet_pkg::ST_APPEND : lruet_pkg::ST_SHIFT_RD;
            end
            lruet_pkg::ST_MISS:
            begin
                // full list: make room first, that eviction is the one reported
                state_next = (count_reg == lruet_pkg::CNT_W'(lruet_pkg::LIST_DEPTH))
                             ? lruet_pkg::ST_EVICT_RD : lruet_pkg::ST_APPEND;
            end
            lruet_pkg::ST_APPEND:
            begin
                state_next = lruet_pkg::ST_CHECK;
            end
            lruet_pkg::ST_CHECK:
            begin
                state_next = (!evicted_reg && over_cap) ? lruet_pkg::ST_EVICT_RD
                                                        : lruet_pkg::ST_REPORT;
            end
            lruet_pkg::ST_EVICT_RD:
            begin
                state_next = lruet_pkg::ST_EVICT_GET;
            end
            lruet_pkg::ST_EVICT_GET:
            begin
                state_next = appended_reg ? lruet_pkg::ST_REPORT : lruet_pkg::ST_APPEND;
            end
            lruet_pkg::ST_REPORT:
            begin
                state_next = lruet_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lruet_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and RAM control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = head_reg + idx_reg;
        ram_raddr = head_reg + idx_reg;
        case (state_reg)
            lruet_pkg::ST_SHIFT_RD:
            begin
                ram_raddr = head_reg + idx_reg + lruet_pkg::IDX_W'(1);
            end
            lruet_pkg::ST_SHIFT_WR:
            begin
                ram_we = 1'b1;
            end
            lruet_pkg::ST_APPEND:
            begin
                ram_we    = 1'b1;
                ram_waddr = head_reg + append_pos[lruet_pkg::IDX_W-1:0];
            end
            lruet_pkg::ST_EVICT_RD:
            begin
                ram_raddr = head_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign busy        = (state_reg != lruet_pkg::ST_IDLE);
    assign done        = (state_reg == lruet_pkg::ST_REPORT);
    assign was_present = hit_reg;
    assign evict_valid = evicted_reg;
    assign evict_kind  = victim_kind_reg;
    assign evict_id    = victim_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lruet_pkg::ST_IDLE;
            idx_reg      <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            capacity_reg <= lruet_pkg::CAPACITY_RESET;
            hit_reg      <= 1'b0;
            evicted_reg  <= 1'b0;
            appended_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            case (state_reg)
                lruet_pkg::ST_IDLE:
                begin
                    if (start)
                    begin
                        idx_reg      <= '0;
                        hit_reg      <= 1'b0;
                        evicted_reg  <= 1'b0;
                        appended_reg <= 1'b0;
                    end
                end
                lruet_pkg::ST_SRCH_CMP:
                begin
                    if (key_match)
                    begin
                        hit_reg <= 1'b1;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + lruet_pkg::IDX_W'(1);
                    end
                end
                lruet_pkg::ST_SHIFT_WR:
                begin
                    idx_reg <= idx_reg + lruet_pkg::IDX_W'(1);
                end
                lruet_pkg::ST_APPEND:
                begin
                    appended_reg <= 1'b1;
                    if (!hit_reg)
                    begin
                        count_reg <= count_reg + lruet_pkg::CNT_W'(1);
                    end
                end
                lruet_pkg::ST_EVICT_GET:
                begin
                    // drop the oldest key by advancing the ring head
                    evicted_reg <= 1'b1;
                    head_reg    <= head_reg + lruet_pkg::IDX_W'(1);
                    count_reg   <= count_reg - lruet_pkg::CNT_W'(1);
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // key and victim payload
    always_ff @(posedge clk)
    begin
        if (state_reg == lruet_pkg::ST_IDLE && start)
        begin
            key_kind_reg    <= entry_kind;
            key_id_reg      <= entry_id;
            victim_kind_reg <= '0;
            victim_id_reg   <= '0;
        end
        else if (state_reg == lruet_pkg::ST_EVICT_GET)
        begin
            {victim_kind_reg, victim_id_reg} <= ram_rdata;
        end
    end

endmodule
